// ----- rtl/tcs_pkg.sv -----
package tcs_pkg;

    // Q2.30 sine/cosine and Q3.29 angle carry one guard bit each
    localparam int CS_W = 33;
    localparam int Z_W  = 33;

    typedef logic signed [CS_W-1:0] t_cs;
    typedef logic signed [Z_W-1:0]  t_angle;

    localparam int ANGLE_PI      = 1686629713;
    localparam int ANGLE_HALF_PI = 843314857;
    localparam int CORDIC_GAIN   = 652032874;

    // round(atan(2^-i) * 2^29)
    localparam int ATAN_Q29 [32] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758, 8387925,
        4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0
    };

endpackage

// ----- rtl/tcs_in_if.sv -----
interface tcs_in_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] pose_x;
    logic signed [W-1:0] pose_y;
    logic signed [31:0]  heading;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;

    modport source (output valid, pose_x, pose_y, heading, point_x, point_y, input ready);
    modport sink   (input valid, pose_x, pose_y, heading, point_x, point_y, output ready);
endinterface

// ----- rtl/tcs_out_if.sv -----
interface tcs_out_if #(
    parameter int W = 32
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] center_x;
    logic signed [W-1:0] center_y;
    logic        [W-2:0] radius;
    logic                degenerate;
    logic                saturated;

    modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                    input ready);
    modport sink   (input valid, center_x, center_y, radius, degenerate, saturated,
                    output ready);
endinterface

// ----- rtl/tcs_cordic_cell.sv -----
module tcs_cordic_cell #(
    parameter int IDX   = 0,
    parameter int PAY_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_v,
    input  tcs_pkg::t_cs         i_x,
    input  tcs_pkg::t_cs         i_y,
    input  tcs_pkg::t_angle      i_z,
    input  logic [PAY_W-1:0]     i_pay,
    output logic                 o_v,
    output tcs_pkg::t_cs         o_x,
    output tcs_pkg::t_cs         o_y,
    output tcs_pkg::t_angle      o_z,
    output logic [PAY_W-1:0]     o_pay
);
    localparam tcs_pkg::t_angle A = tcs_pkg::Z_W'(tcs_pkg::ATAN_Q29[IDX]);

    tcs_pkg::t_cs    xs, ys, n_x, n_y;
    tcs_pkg::t_angle n_z;
    logic            r_v;
    tcs_pkg::t_cs    r_x, r_y;
    tcs_pkg::t_angle r_z;
    logic [PAY_W-1:0] r_pay;

    always_comb begin
        xs = i_x >>> IDX;
        ys = i_y >>> IDX;
        if (!i_z[tcs_pkg::Z_W-1]) begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - A;
        end else begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_pay <= i_pay;
        end
    end

    assign o_v   = r_v;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_pay = r_pay;
endmodule

// ----- rtl/tcs_div_cell.sv -----
module tcs_div_cell #(
    parameter int DW    = 36,
    parameter int LW    = 34,
    parameter int PAY_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_v,
    input  logic [DW-1:0]    i_rem,
    input  logic [LW-1:0]    i_lo,
    input  logic [DW-1:0]    i_d,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_v,
    output logic [DW-1:0]    o_rem,
    output logic [LW-1:0]    o_lo,
    output logic [DW-1:0]    o_d,
    output logic [PAY_W-1:0] o_pay
);
    logic [DW:0]      rem_t;
    logic             ge;
    logic [DW-1:0]    n_rem;
    logic             r_v;
    logic [DW-1:0]    r_rem, r_d;
    logic [LW-1:0]    r_lo;
    logic [PAY_W-1:0] r_pay;

    // low word shifts numerator bits out the top and quotient bits in the bottom
    always_comb begin
        rem_t = {i_rem, i_lo[LW-1]};
        ge    = rem_t >= {1'b0, i_d};
        n_rem = ge ? DW'(rem_t - {1'b0, i_d}) : DW'(rem_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_lo  <= {i_lo[LW-2:0], ge};
            r_d   <= i_d;
            r_pay <= i_pay;
        end
    end

    assign o_v   = r_v;
    assign o_rem = r_rem;
    assign o_lo  = r_lo;
    assign o_d   = r_d;
    assign o_pay = r_pay;
endmodule

// ----- rtl/tangent_circle_solver.sv -----
// Circle through a target point, tangent to a pose. Fully pipelined: one request
// is taken every cycle while the output skid entry is empty, and each result passes
// through an input stage, a chain of ROTATION_STAGES CORDIC cells for the sine
// and cosine, then a chain of COORD_WIDTH + 2 restoring-divider cells for the
// center offset, plus product, rounding and saturation stages. A two-entry
// output buffer lets requests keep flowing while a result waits to be taken.
// When the point lies on the tangent line the result is flagged degenerate with
// zero center and radius.
module tangent_circle_solver #(
    parameter int COORD_WIDTH     = 32,
    parameter int ROTATION_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcs_in_if.sink      i_req,
    tcs_out_if.source   o_res
);
    localparam int W   = COORD_WIDTH;
    localparam int N   = ROTATION_STAGES;
    localparam int CW  = tcs_pkg::CS_W;
    localparam int ZW  = tcs_pkg::Z_W;
    localparam int DXW = W + 1;
    localparam int PW  = W + 37;
    localparam int UW  = W + 4;
    localparam int AW  = W + 3;
    localparam int NW  = 2 * AW + 2;
    localparam int QW  = W + 2;
    localparam int DW  = AW + 1;
    localparam int HW  = NW - QW;
    localparam int MW  = QW + 1;
    localparam int XW  = W + 7;
    localparam int CP  = 2 * W + 2 * DXW + 1;
    localparam int DP  = 2 * W + 2 * CW + 3;
    localparam int RW  = 3 * W + 1;

    localparam logic [QW-1:0] LIM = QW'(1) << (W + 1);
    localparam logic [QW-1:0] RMAX = QW'({(W-1){1'b1}});
    localparam logic signed [XW-1:0] SMAX = XW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
        logic [PW-1:0] mg;
        logic [PW-1:0] r;
        mg = p[PW-1] ? PW'(-p) : PW'(p);
        r  = (mg + (PW'(1) << 29)) >> 30;
        return p[PW-1] ? -signed'(r) : signed'(r);
    endfunction

    logic en, acc;
    logic r_skid_v, r_out_v;
    logic [RW-1:0] r_skid, r_out;

    assign en          = !r_skid_v;
    assign acc         = i_req.valid && en;
    assign i_req.ready = en;

    // ---- input stage: half-turn fold and differences
    tcs_pkg::t_angle h, zf;
    logic            fl;
    logic            r0_val, r0_flip;
    tcs_pkg::t_angle r0_z;
    logic signed [W-1:0]   r0_px, r0_py;
    logic signed [DXW-1:0] r0_dx, r0_dy;

    always_comb begin
        h  = ZW'(i_req.heading);
        zf = h;
        fl = 1'b0;
        if (h > ZW'(tcs_pkg::ANGLE_HALF_PI)) begin
            zf = h - ZW'(tcs_pkg::ANGLE_PI);
            fl = 1'b1;
        end else if (h < -ZW'(tcs_pkg::ANGLE_HALF_PI)) begin
            zf = h + ZW'(tcs_pkg::ANGLE_PI);
            fl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_val <= 1'b0;
        end else if (en) begin
            r0_val <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_z    <= zf;
            r0_flip <= fl;
            r0_px   <= i_req.pose_x;
            r0_py   <= i_req.pose_y;
            r0_dx   <= DXW'(i_req.point_x) - DXW'(i_req.pose_x);
            r0_dy   <= DXW'(i_req.point_y) - DXW'(i_req.pose_y);
        end
    end

    // ---- CORDIC chain
    logic            cv [0:N];
    tcs_pkg::t_cs    cx [0:N];
    tcs_pkg::t_cs    cy [0:N];
    tcs_pkg::t_angle cz [0:N];
    logic [CP-1:0]   cp [0:N];

    assign cv[0] = r0_val;
    assign cx[0] = CW'(tcs_pkg::CORDIC_GAIN);
    assign cy[0] = '0;
    assign cz[0] = r0_z;
    assign cp[0] = {r0_px, r0_py, r0_dx, r0_dy, r0_flip};

    for (genvar g = 0; g < N; g++) begin : g_cordic
        tcs_cordic_cell #(.IDX(g), .PAY_W(CP)) u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_v (cv[g]), .i_x (cx[g]), .i_y (cy[g]), .i_z (cz[g]), .i_pay (cp[g]),
            .o_v (cv[g+1]), .o_x (cx[g+1]), .o_y (cy[g+1]), .o_z (cz[g+1]),
            .o_pay (cp[g+1])
        );
    end

    // ---- local-frame products
    logic signed [W-1:0]   e_px, e_py;
    logic signed [DXW-1:0] e_dx, e_dy;
    logic                  e_flip;
    tcs_pkg::t_cs          e_c, e_s;

    always_comb begin
        e_px   = cp[N][CP-1 -: W];
        e_py   = cp[N][CP-1-W -: W];
        e_dx   = cp[N][2*DXW : DXW+1];
        e_dy   = cp[N][DXW : 1];
        e_flip = cp[N][0];
        e_c    = e_flip ? -cx[N] : cx[N];
        e_s    = e_flip ? -cy[N] : cy[N];
    end

    logic r1_val;
    logic signed [PW-1:0] r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [W-1:0]  r1_px, r1_py;
    tcs_pkg::t_cs         r1_c, r1_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_val <= 1'b0;
        end else if (en) begin
            r1_val <= cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pa <= PW'(e_dx) * PW'(e_c);
            r1_pb <= PW'(e_dy) * PW'(e_s);
            r1_pc <= PW'(e_dy) * PW'(e_c);
            r1_pd <= PW'(e_dx) * PW'(e_s);
            r1_px <= e_px;
            r1_py <= e_py;
            r1_c  <= e_c;
            r1_s  <= e_s;
        end
    end

    // ---- rounded u, v
    logic r2_val;
    logic signed [UW-1:0] r2_lu, r2_lv;
    logic signed [W-1:0]  r2_px, r2_py;
    tcs_pkg::t_cs         r2_c, r2_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_val <= 1'b0;
        end else if (en) begin
            r2_val <= r1_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_lu <= UW'(rnd(r1_pa) + rnd(r1_pb));
            r2_lv <= UW'(rnd(r1_pc) - rnd(r1_pd));
            r2_px <= r1_px;
            r2_py <= r1_py;
            r2_c  <= r1_c;
            r2_s  <= r1_s;
        end
    end

    // ---- magnitudes
    logic r3_val, r3_neg, r3_deg;
    logic [AW-1:0]        r3_au, r3_av;
    logic signed [W-1:0]  r3_px, r3_py;
    tcs_pkg::t_cs         r3_c, r3_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_val <= 1'b0;
        end else if (en) begin
            r3_val <= r2_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_au  <= r2_lu[UW-1] ? AW'(-r2_lu) : AW'(r2_lu);
            r3_av  <= r2_lv[UW-1] ? AW'(-r2_lv) : AW'(r2_lv);
            r3_neg <= r2_lv[UW-1];
            r3_deg <= r2_lv == '0;
            r3_px  <= r2_px;
            r3_py  <= r2_py;
            r3_c   <= r2_c;
            r3_s   <= r2_s;
        end
    end

    // ---- squares
    logic r4_val, r4_neg, r4_deg;
    logic [2*AW-1:0]      r4_uu, r4_vv;
    logic [AW-1:0]        r4_av;
    logic signed [W-1:0]  r4_px, r4_py;
    tcs_pkg::t_cs         r4_c, r4_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_val <= 1'b0;
        end else if (en) begin
            r4_val <= r3_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_uu  <= (2*AW)'(r3_au) * (2*AW)'(r3_au);
            r4_vv  <= (2*AW)'(r3_av) * (2*AW)'(r3_av);
            r4_av  <= r3_av;
            r4_neg <= r3_neg;
            r4_deg <= r3_deg;
            r4_px  <= r3_px;
            r4_py  <= r3_py;
            r4_c   <= r3_c;
            r4_s   <= r3_s;
        end
    end

    // ---- numerator u^2 + v^2 + |v| (the |v| term rounds the quotient) and divisor 2|v|
    logic r5_val, r5_neg, r5_deg;
    logic [NW-1:0]        r5_num;
    logic [DW-1:0]        r5_d;
    logic signed [W-1:0]  r5_px, r5_py;
    tcs_pkg::t_cs         r5_c, r5_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_val <= 1'b0;
        end else if (en) begin
            r5_val <= r4_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_num <= NW'(r4_uu) + NW'(r4_vv) + NW'(r4_av);
            r5_d   <= {r4_av, 1'b0};
            r5_neg <= r4_neg;
            r5_deg <= r4_deg;
            r5_px  <= r4_px;
            r5_py  <= r4_py;
            r5_c   <= r4_c;
            r5_s   <= r4_s;
        end
    end

    // ---- divider setup: quotient beyond QW bits is already past the clamp
    logic r6_val, r6_ovf;
    logic [DW-1:0]  r6_rem, r6_d;
    logic [QW-1:0]  r6_lo;
    logic [DP-1:0]  r6_pay;
    logic [HW-1:0]  hi;

    assign hi = r5_num[NW-1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_val <= 1'b0;
        end else if (en) begin
            r6_val <= r5_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_ovf <= hi >= HW'(r5_d);
            r6_rem <= DW'(hi);
            r6_lo  <= r5_num[QW-1:0];
            r6_d   <= r5_d;
            r6_pay <= {r5_px, r5_py, r5_c, r5_s, r5_neg, r5_deg, 1'b0};
        end
    end

    // ---- divider chain
    logic          dv [0:QW];
    logic [DW-1:0] dr [0:QW];
    logic [QW-1:0] dl [0:QW];
    logic [DW-1:0] dd [0:QW];
    logic [DP-1:0] dp [0:QW];

    assign dv[0] = r6_val;
    assign dr[0] = r6_rem;
    assign dl[0] = r6_lo;
    assign dd[0] = r6_d;
    assign dp[0] = {r6_pay[DP-1:1], r6_ovf};

    for (genvar g = 0; g < QW; g++) begin : g_div
        tcs_div_cell #(.DW(DW), .LW(QW), .PAY_W(DP)) u_cell (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_v (dv[g]), .i_rem (dr[g]), .i_lo (dl[g]), .i_d (dd[g]), .i_pay (dp[g]),
            .o_v (dv[g+1]), .o_rem (dr[g+1]), .o_lo (dl[g+1]), .o_d (dd[g+1]),
            .o_pay (dp[g+1])
        );
    end

    // ---- clamp and back-rotation products
    logic signed [W-1:0] f_px, f_py;
    tcs_pkg::t_cs        f_c, f_s;
    logic                f_neg, f_deg, f_ovf;
    logic [QW-1:0]       f_q;
    logic signed [MW-1:0] f_m;

    always_comb begin
        f_px  = dp[QW][DP-1 -: W];
        f_py  = dp[QW][DP-1-W -: W];
        f_c   = dp[QW][2*CW+2 : CW+3];
        f_s   = dp[QW][CW+2 : 3];
        f_neg = dp[QW][2];
        f_deg = dp[QW][1];
        f_ovf = dp[QW][0];
        f_q   = (f_ovf || dl[QW] > LIM) ? LIM : dl[QW];
        f_m   = f_neg ? -signed'({1'b0, f_q}) : signed'({1'b0, f_q});
    end

    logic r7_val, r7_deg;
    logic signed [PW-1:0] r7_ms, r7_mc;
    logic signed [W-1:0]  r7_px, r7_py;
    logic [QW-1:0]        r7_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_val <= 1'b0;
        end else if (en) begin
            r7_val <= dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ms  <= PW'(f_m) * PW'(f_s);
            r7_mc  <= PW'(f_m) * PW'(f_c);
            r7_px  <= f_px;
            r7_py  <= f_py;
            r7_q   <= f_q;
            r7_deg <= f_deg;
        end
    end

    // ---- center, radius, saturation
    logic signed [XW-1:0] wx, wy;
    logic signed [W-1:0]  ox, oy;
    logic [W-2:0]         orad;
    logic                 oclip;
    logic [RW-1:0]        res;

    always_comb begin
        wx    = XW'(r7_px) - XW'(rnd(r7_ms));
        wy    = XW'(r7_py) + XW'(rnd(r7_mc));
        oclip = 1'b0;
        if (wx > SMAX) begin
            ox = W'(SMAX); oclip = 1'b1;
        end else if (wx < SMIN) begin
            ox = W'(SMIN); oclip = 1'b1;
        end else begin
            ox = W'(wx);
        end
        if (wy > SMAX) begin
            oy = W'(SMAX); oclip = 1'b1;
        end else if (wy < SMIN) begin
            oy = W'(SMIN); oclip = 1'b1;
        end else begin
            oy = W'(wy);
        end
        if (r7_q > RMAX) begin
            orad = (W-1)'(RMAX); oclip = 1'b1;
        end else begin
            orad = (W-1)'(r7_q);
        end
        if (r7_deg) begin
            res = {W'(0), W'(0), (W-1)'(0), 1'b1, 1'b0};
        end else begin
            res = {ox, oy, orad, 1'b0, oclip};
        end
    end

    // ---- output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_out_v && !o_res.ready) begin
            if (r7_val && en) begin
                r_skid_v <= 1'b1;
            end
        end else if (r_skid_v) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v <= r7_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_v && !o_res.ready) begin
            if (en) begin
                r_skid <= res;
            end
        end else if (r_skid_v) begin
            r_out <= r_skid;
        end else begin
            r_out <= res;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.center_x   = r_out[RW-1 -: W];
    assign o_res.center_y   = r_out[RW-1-W -: W];
    assign o_res.radius     = r_out[W : 2];
    assign o_res.degenerate = r_out[1];
    assign o_res.saturated  = r_out[0];
endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int W        = 32;
    localparam int STAGES   = 24;
    localparam int LATENCY  = STAGES + W + 11;
    localparam int N_RANDOM = 1030;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] heading;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [30:0] radius;
        logic               degenerate;
        logic               saturated;
    } t_circle;

    typedef struct {
        t_req    req;
        bit      known;
        t_circle res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcs_in_if  #(.W(W)) req_if ();
    tcs_out_if #(.W(W)) res_if ();

    tangent_circle_solver #(.COORD_WIDTH(W), .ROTATION_STAGES(STAGES)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always #4 i_clk = ~i_clk;

    t_circle circle_q[$];
    int      n_err = 0;
    bit      done = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        n_err++;
    endtask

    function automatic longint round_mul(longint a, longint b);
        logic [127:0] p;
        longint r;
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        r = longint'((p + (128'(1) << 29)) >> 30);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint clip32(longint x, ref bit clip);
        if (x > 64'sd2147483647) begin
            clip = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            clip = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic t_circle solve_circle(t_req r);
        longint x, y, z, xs, ys, c, s, dx, dy, u, v, m, cx, cy;
        logic [127:0] num, den, q;
        bit flip, clip;
        t_circle o;
        x = tcs_pkg::CORDIC_GAIN;
        y = 0;
        z = r.heading;
        flip = 1'b0;
        clip = 1'b0;
        if (z > tcs_pkg::ANGLE_HALF_PI) begin
            z -= tcs_pkg::ANGLE_PI;
            flip = 1'b1;
        end else if (z < -tcs_pkg::ANGLE_HALF_PI) begin
            z += tcs_pkg::ANGLE_PI;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= tcs_pkg::ATAN_Q29[i];
            end else begin
                x += ys; y -= xs; z += tcs_pkg::ATAN_Q29[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        dx = longint'(r.point_x) - r.pose_x;
        dy = longint'(r.point_y) - r.pose_y;
        u = round_mul(dx, c) + round_mul(dy, s);
        v = round_mul(dy, c) - round_mul(dx, s);
        o = '0;
        if (v == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        if (u < 0) u = -u;
        if (v < 0) begin
            v = -v;
            flip = 1'b1;
        end else begin
            flip = 1'b0;
        end
        num = 128'(u) * 128'(u) + 128'(v) * 128'(v) + 128'(v);
        den = 128'(v) << 1;
        q = num / den;
        if (q > (128'(1) << 33)) q = 128'(1) << 33;
        m = flip ? -longint'(q) : longint'(q);
        cx = clip32(longint'(r.pose_x) - round_mul(m, s), clip);
        cy = clip32(longint'(r.pose_y) + round_mul(m, c), clip);
        if (q > 128'h7FFF_FFFF) begin
            q = 128'h7FFF_FFFF;
            clip = 1'b1;
        end
        o.center_x = cx[31:0];
        o.center_y = cy[31:0];
        o.radius = q[30:0];
        o.saturated = clip;
        return o;
    endfunction

    task automatic send(t_req r);
        while ($urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : 1) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.pose_x  <= r.pose_x;
        req_if.pose_y  <= r.pose_y;
        req_if.heading <= r.heading;
        req_if.point_x <= r.point_x;
        req_if.point_y <= r.point_y;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return 32'($signed(16'($urandom)));
            1: return 32'($signed(24'($urandom)));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // directed rows; expected value typed in for degenerate cases only
    t_row rows[$];

    function automatic t_row mk(int px, int py, int h, int qx, int qy, bit known = 0);
        t_row t;
        t.req = '{px, py, h, qx, qy};
        t.known = known;
        t.res = '0;
        t.res.degenerate = 1'b1;
        return t;
    endfunction

    initial begin
        t_req   r;
        req_if.valid = 1'b0;
        req_if.pose_x = '0;
        req_if.pose_y = '0;
        req_if.heading = '0;
        req_if.point_x = '0;
        req_if.point_y = '0;
        rows = '{
            mk(0, 0, 0, 0, 0, 1),
            mk(1000, -5000, 0, 70000, -5000, 1),
            mk(0, 0, 0, 65536, 65536),
            mk(0, 0, 0, 0, -65536),
            mk(0, 0, tcs_pkg::ANGLE_HALF_PI, 65536, 65536),
            mk(0, 0, -tcs_pkg::ANGLE_HALF_PI, 65536, -65536),
            mk(0, 0, tcs_pkg::ANGLE_PI, 131072, 65536),
            mk(0, 0, -tcs_pkg::ANGLE_PI, -131072, -65536),
            mk(0, 0, 32'h7FFF_FFFF, 3, 65536),
            mk(0, 0, 32'h8000_0000, -3, 65536),
            mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000),
            mk(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
            mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1),
            mk(0, 0, 0, 32'h7FFF_FFFF, 1),
            mk(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000),
            mk(-1, -1, -1, -1, 0),
            mk(12345, -6789, 400000000, -98765, 43210),
            mk(0, 0, tcs_pkg::ANGLE_HALF_PI + 1, 5, 7),
            mk(0, 0, -tcs_pkg::ANGLE_HALF_PI - 1, 5, 7)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            circle_q = {circle_q,
                        rows[i].known ? rows[i].res : solve_circle(rows[i].req)};
            send(rows[i].req);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            r.pose_x = rand_coord();
            r.pose_y = rand_coord();
            case ($urandom_range(0, 9))
                0: r.heading = $urandom;
                1: r.heading = $urandom_range(0, 1) ? tcs_pkg::ANGLE_PI : -tcs_pkg::ANGLE_PI;
                default: r.heading = $urandom_range(0, 2 * $unsigned(tcs_pkg::ANGLE_PI))
                                     - $unsigned(tcs_pkg::ANGLE_PI);
            endcase
            r.point_x = rand_coord();
            r.point_y = rand_coord();
            if ($urandom_range(0, 15) == 0) begin
                r.point_x = r.pose_x;
                r.point_y = r.pose_y;
            end else if ($urandom_range(0, 15) == 0) begin
                r.heading = 0;
                r.point_y = r.pose_y;
            end
            circle_q = {circle_q, solve_circle(r)};
            send(r);
        end
        req_if.valid <= 1'b0;
        while (circle_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        done = 1'b1;
    end

    // result side: random stalls, check on each handshake
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                if (circle_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    t_circle e;
                    e = circle_q.pop_front();
                    if (res_if.center_x !== e.center_x)
                        report("center_x", res_if.center_x, e.center_x);
                    if (res_if.center_y !== e.center_y)
                        report("center_y", res_if.center_y, e.center_y);
                    if (res_if.radius !== e.radius)
                        report("radius", res_if.radius, e.radius);
                    if (res_if.degenerate !== e.degenerate)
                        report("degenerate", res_if.degenerate, e.degenerate);
                    if (res_if.saturated !== e.saturated)
                        report("saturated", res_if.saturated, e.saturated);
                end
            end
            if ($urandom_range(0, 99) < 3)
                res_if.ready <= 1'b0;
            else if ($urandom_range(0, 3) != 0)
                res_if.ready <= 1'b1;
            else
                res_if.ready <= ($urandom_range(0, 1) == 1);
        end
    end

    initial begin
        wait (done);
        if (n_err == 0 && circle_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
